// ===== rtl/lpcd_pkg.sv =====
`default_nettype none

package lpcd_pkg;

	localparam int NUM_PIXELS_DEF = 256;
	localparam int CHAN_W = 8;
	localparam int RAND_W = 7;
	localparam int INDEX_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	localparam int HUE_ROTATE = 170;
	localparam int HUE_REGION = 43;
	localparam int HUE_SCALE = 6;
	localparam int CHAN_MAX = 255;
	localparam int RAND_LIMIT = 100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_HUE = 3'd0,
		CFG_BASE_ON = 3'd1,
		CFG_MUT_ENABLE = 3'd2,
		CFG_MUT_STEP = 3'd3,
		CFG_BOUND_SIZE = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [INDEX_W-1:0] pixel_index;
		logic [RAND_W-1:0] rand_red;
		logic [RAND_W-1:0] rand_green;
		logic [RAND_W-1:0] rand_blue;
	} pix_req_t;

	typedef struct packed {
		logic [INDEX_W-1:0] out_index;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pix_rsp_t;

	typedef struct packed {
		logic mutate;
		logic [CHAN_W-1:0] step;
		logic [CHAN_W-1:0] bound;
	} drift_cfg_t;

	typedef logic [3*CHAN_W-1:0] rgb_table_t [256];

	function automatic logic [3*CHAN_W-1:0] hue_to_rgb(input int hue);
		int h;
		int region;
		int rem;
		int q;
		int t;
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		h = hue + HUE_ROTATE;
		if (h > CHAN_MAX) begin
			h = h - CHAN_MAX;
		end
		region = h / HUE_REGION;
		rem = (h - region * HUE_REGION) * HUE_SCALE;
		q = (CHAN_MAX * (CHAN_MAX - ((CHAN_MAX * rem) >> 8))) >> 8;
		t = (CHAN_MAX * (CHAN_MAX - ((CHAN_MAX * (CHAN_MAX - rem)) >> 8))) >> 8;
		case (region)
			0: begin
				r = 8'd255; g = CHAN_W'(t); b = 8'd0;
			end
			1: begin
				r = CHAN_W'(q); g = 8'd255; b = 8'd0;
			end
			2: begin
				r = 8'd0; g = 8'd255; b = CHAN_W'(t);
			end
			3: begin
				r = 8'd0; g = CHAN_W'(q); b = 8'd255;
			end
			4: begin
				r = CHAN_W'(t); g = 8'd0; b = 8'd255;
			end
			default: begin
				r = 8'd255; g = 8'd0; b = CHAN_W'(q);
			end
		endcase
		return {r, g, b};
	endfunction

	function automatic rgb_table_t build_hue_table();
		rgb_table_t tab;
		for (int i = 0; i < 256; i++) begin
			tab[i] = hue_to_rgb(i);
		end
		return tab;
	endfunction

	localparam rgb_table_t HUE_TABLE = build_hue_table();

endpackage

`default_nettype wire

// ===== rtl/lpcd_ram.sv =====
`default_nettype none

module lpcd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [ADDR_W-1:0] wr_addr,
	input wire logic [WIDTH-1:0] wr_data,
	input wire logic rd_en,
	input wire logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lpcd_lane.sv =====
`default_nettype none

module lpcd_lane (
	input wire logic [lpcd_pkg::CHAN_W-1:0] pix,
	input wire logic [lpcd_pkg::RAND_W-1:0] rnd,
	input wire logic [lpcd_pkg::CHAN_W-1:0] base,
	input wire lpcd_pkg::drift_cfg_t cfg,
	output logic [lpcd_pkg::CHAN_W-1:0] nxt
);

	import lpcd_pkg::*;

	logic [CHAN_W:0] up_sum;
	logic [CHAN_W-1:0] up_val;
	logic [CHAN_W-1:0] down_val;
	logic [CHAN_W-1:0] mut_val;
	logic step_ok;
	logic [CHAN_W:0] hi_lim;
	logic [CHAN_W:0] lo_chk;

	always_comb begin
		up_sum = {1'b0, pix} + {1'b0, cfg.step};
		up_val = up_sum[CHAN_W] ? CHAN_W'(CHAN_MAX) : up_sum[CHAN_W-1:0];
		down_val = (pix < cfg.step) ? '0 : pix - cfg.step;
		step_ok = cfg.mutate && (rnd < RAND_W'(RAND_LIMIT));
		if (step_ok) begin
			mut_val = rnd[0] ? up_val : down_val;
		end else begin
			mut_val = pix;
		end
		hi_lim = {1'b0, base} + {1'b0, cfg.bound};
		lo_chk = {1'b0, mut_val} + {1'b0, cfg.bound};
		if ({1'b0, mut_val} > hi_lim) begin
			nxt = mut_val - CHAN_W'(1);
		end else if (lo_chk < {1'b0, base}) begin
			nxt = mut_val + CHAN_W'(1);
		end else begin
			nxt = mut_val;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/led_pixel_color_drift.sv =====
// Pixel color store in which every update lets one pixel drift at random around a base color.
// Request channel (req, req_valid, req_stall): one item names a pixel and carries three
// random values. Response channel (rsp, rsp_valid, rsp_stall): one item per request with
// the reduced pixel index and its new red, green and blue values.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is always
// high; writes to an index beyond the register list are ignored. Write only while idle.
// After a request is accepted, the store is read and the request is held in the stage register;
// the three channel lanes load the response register as that stage advances, raising rsp_valid.
// A new request is taken in every cycle unless req_stall is high; the read-modify-write of
// the store is covered by forwarding the last written pixel, so back-to-back updates of one
// pixel are exact. After reset the store is cleared to black, one pixel per cycle; req_stall
// stays high until the last pixel is written. Configuration writes are taken at once.
// When rsp_stall is high the response holds, the lane stage fills, and then req_stall rises
// in the same cycle, so no item is lost.
`default_nettype none

module led_pixel_color_drift #(
	parameter int NUM_PIXELS = lpcd_pkg::NUM_PIXELS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire lpcd_pkg::pix_req_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output lpcd_pkg::pix_rsp_t rsp,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [lpcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [lpcd_pkg::CFG_DATA_W-1:0] cfg_data
);

	import lpcd_pkg::*;

	localparam int IDX_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
	localparam int PIX_W = 3 * CHAN_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PIXELS - 1);

	typedef logic [IDX_W-1:0] idx_map_t [256];

	function automatic idx_map_t build_idx_map();
		idx_map_t m;
		int r;
		r = 0;
		for (int i = 0; i < 256; i++) begin
			m[i] = IDX_W'(r);
			if (r == NUM_PIXELS - 1) begin
				r = 0;
			end else begin
				r = r + 1;
			end
		end
		return m;
	endfunction

	localparam idx_map_t IDX_MAP = build_idx_map();

	logic [CHAN_W-1:0] base_hue_q;
	logic base_on_q;
	drift_cfg_t drift_cfg_q;
	logic [PIX_W-1:0] base_q;

	logic clearing_q;
	logic [IDX_W-1:0] clr_idx_q;

	logic req_accept;
	logic [IDX_W-1:0] req_idx;

	logic s1_valid_q;
	logic [IDX_W-1:0] idx_s1;
	pix_req_t req_s1;
	logic s1_adv;

	logic fwd_valid_q;
	logic [IDX_W-1:0] fwd_idx_q;
	logic [PIX_W-1:0] fwd_data_q;

	logic [PIX_W-1:0] rd_data;
	logic [PIX_W-1:0] cur_pix;
	logic [PIX_W-1:0] new_pix;
	logic [CHAN_W-1:0] new_red;
	logic [CHAN_W-1:0] new_green;
	logic [CHAN_W-1:0] new_blue;
	logic [IDX_W+INDEX_W-1:0] idx_wide;

	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [PIX_W-1:0] wr_data;

	logic out_valid_q;
	pix_rsp_t out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_hue_q <= '0;
			base_on_q <= 1'b0;
			drift_cfg_q.mutate <= 1'b0;
			drift_cfg_q.step <= CHAN_W'(2);
			drift_cfg_q.bound <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BASE_HUE: base_hue_q <= cfg_data;
				CFG_BASE_ON: base_on_q <= cfg_data[0];
				CFG_MUT_ENABLE: drift_cfg_q.mutate <= cfg_data[0];
				CFG_MUT_STEP: drift_cfg_q.step <= cfg_data;
				CFG_BOUND_SIZE: drift_cfg_q.bound <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else begin
			base_q <= base_on_q ? HUE_TABLE[base_hue_q] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == LAST_IDX) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign s1_adv = s1_valid_q && (!out_valid_q || !rsp_stall);
	assign req_stall = clearing_q || (s1_valid_q && !s1_adv);
	assign req_accept = req_valid && !req_stall;
	assign req_idx = IDX_MAP[req.pixel_index];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			idx_s1 <= req_idx;
			req_s1 <= req;
		end
	end

	always_comb begin
		if (clearing_q) begin
			wr_en = 1'b1;
			wr_addr = clr_idx_q;
			wr_data = '0;
		end else begin
			wr_en = s1_adv;
			wr_addr = idx_s1;
			wr_data = new_pix;
		end
	end

	lpcd_ram #(
		.WIDTH(PIX_W),
		.DEPTH(NUM_PIXELS),
		.ADDR_W(IDX_W)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(req_accept),
		.rd_addr(req_idx),
		.rd_data(rd_data)
	);

	// The store returns old data when a pixel is read at the edge where it is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (s1_adv) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			fwd_idx_q <= idx_s1;
			fwd_data_q <= new_pix;
		end
	end

	assign cur_pix = (fwd_valid_q && (fwd_idx_q == idx_s1)) ? fwd_data_q : rd_data;

	lpcd_lane u_lane_red (
		.pix(cur_pix[3*CHAN_W-1:2*CHAN_W]),
		.rnd(req_s1.rand_red),
		.base(base_q[3*CHAN_W-1:2*CHAN_W]),
		.cfg(drift_cfg_q),
		.nxt(new_red)
	);

	lpcd_lane u_lane_green (
		.pix(cur_pix[2*CHAN_W-1:CHAN_W]),
		.rnd(req_s1.rand_green),
		.base(base_q[2*CHAN_W-1:CHAN_W]),
		.cfg(drift_cfg_q),
		.nxt(new_green)
	);

	lpcd_lane u_lane_blue (
		.pix(cur_pix[CHAN_W-1:0]),
		.rnd(req_s1.rand_blue),
		.base(base_q[CHAN_W-1:0]),
		.cfg(drift_cfg_q),
		.nxt(new_blue)
	);

	assign new_pix = {new_red, new_green, new_blue};
	assign idx_wide = {{INDEX_W{1'b0}}, idx_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.out_index <= idx_wide[INDEX_W-1:0];
			out_q.red <= new_red;
			out_q.green <= new_green;
			out_q.blue <= new_blue;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

endmodule

`default_nettype wire
